### rtl/u8v_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_pkg: shared types and constants for the UTF-8 validator
// Holds request and verdict payload types, status codes and byte constants.
// ----------------------------------------------------------------------------
package u8v_pkg;

  // Width of the content position counter; it saturates at all ones
  localparam int OFFSET_BITS  = 24;
  localparam int OUT_OFFSET_W = 24;

  // Verdict codes
  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_UTF16   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // Byte-order marks
  localparam logic [7:0] BOM_BYTE0  = 8'hEF;
  localparam logic [7:0] BOM_BYTE1  = 8'hBB;
  localparam logic [7:0] BOM_BYTE2  = 8'hBF;
  localparam logic [7:0] UTF16_FF   = 8'hFF;
  localparam logic [7:0] UTF16_FE   = 8'hFE;

  // Lead byte ranges and second-byte limits
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LIM_E0_MIN = 8'hA0;
  localparam logic [7:0] LIM_ED_MAX = 8'h9F;
  localparam logic [7:0] LIM_F0_MIN = 8'h90;
  localparam logic [7:0] LIM_F4_MAX = 8'h8F;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One verdict
  typedef struct packed {
    logic [1:0]              status;
    logic [OUT_OFFSET_W-1:0] error_offset;
    logic                    has_bom;
  } verdict_t;

  // Number of continuation bytes that follow a held lead byte
  function automatic logic [1:0] cont_count(input logic [7:0] lead);
    if (lead >= LEAD4_MIN) begin
      cont_count = 2'd3;
    end else if (lead >= LEAD3_MIN) begin
      cont_count = 2'd2;
    end else begin
      cont_count = 2'd1;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/u8v_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_in_stage: input request register
// Captures one byte request per cycle while the scanner keeps taking them, and holds each until the scanner takes it.
// ----------------------------------------------------------------------------
module u8v_in_stage
  import u8v_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Accept a new request when empty or when the held one leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

### rtl/u8v_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_scan: per-file scan state and verdict logic
// Tracks marks, the open UTF-8 sequence and the first error for one file.
// ----------------------------------------------------------------------------
module u8v_scan
  import u8v_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  input  wire item_t item,
  input  wire logic  out_free,
  output logic       take,
  output logic       verdict_valid,
  output verdict_t   verdict
);

  localparam pos_t POS_MAX = {OFFSET_BITS{1'b1}};

  pos_t       pos_r, pos_nxt;
  logic [7:0] first_r, first_nxt;
  logic       utf16_r, utf16_nxt;
  logic [1:0] bom_prog_r, bom_prog_nxt;
  logic       bom_r, bom_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [7:0] lead_r, lead_nxt;
  pos_t       lead_pos_r, lead_pos_nxt;
  logic       bad_r, bad_nxt;
  pos_t       bad_pos_r, bad_pos_nxt;
  logic       fault_r, fault_nxt;
  logic       err_r, err_nxt;
  pos_t       err_pos_r, err_pos_nxt;

  logic [7:0] b;
  logic       is_bad;
  logic       range_hit;
  logic [7:0] bom_exp;
  logic       last_err;
  pos_t       last_err_pos;
  pos_t       off;

  assign b = item.data_byte;

  // Advance when a byte waits and its verdict, if any, has room
  assign take          = item_valid && (!item.last_byte || out_free);
  assign verdict_valid = take && item.last_byte;

  always_comb begin
    case (bom_prog_r)
      2'd0:    bom_exp = BOM_BYTE0;
      2'd1:    bom_exp = BOM_BYTE1;
      default: bom_exp = BOM_BYTE2;
    endcase
  end

  assign is_bad    = b[7:6] != CONT_TAG;
  assign range_hit = (lead_r == LEAD3_MIN && b < LIM_E0_MIN) ||
                     (lead_r == LEAD_ED   && b > LIM_ED_MAX) ||
                     (lead_r == LEAD4_MIN && b < LIM_F0_MIN) ||
                     (lead_r == LEAD4_MAX && b > LIM_F4_MAX);

  // Compute next scan state for the current byte
  always_comb begin
    first_nxt    = first_r;
    utf16_nxt    = utf16_r;
    bom_prog_nxt = bom_prog_r;
    bom_nxt      = bom_r;
    exp_nxt      = exp_r;
    lead_nxt     = lead_r;
    lead_pos_nxt = lead_pos_r;
    bad_nxt      = bad_r;
    bad_pos_nxt  = bad_pos_r;
    fault_nxt    = fault_r;
    err_nxt      = err_r;
    err_pos_nxt  = err_pos_r;
    pos_nxt      = (pos_r != POS_MAX) ? pos_r + pos_t'(1) : pos_r;

    // Track the leading marks
    if (pos_r == pos_t'(0)) begin
      first_nxt = b;
    end
    if (pos_r == pos_t'(1) && ((first_r == UTF16_FF && b == UTF16_FE) ||
                               (first_r == UTF16_FE && b == UTF16_FF))) begin
      utf16_nxt = 1'b1;
    end
    if (pos_r < pos_t'(3) && pos_t'(bom_prog_r) == pos_r && b == bom_exp) begin
      bom_prog_nxt = bom_prog_r + 2'd1;
      if (pos_r == pos_t'(2)) begin
        bom_nxt = 1'b1;
      end
    end

    // Check UTF-8 until the first error
    if (!err_r) begin
      if (exp_r == 2'd0) begin
        if (b <= ASCII_MAX || (b >= LEAD2_MIN && b <= LEAD2_MAX) ||
            (b >= LEAD3_MIN && b <= LEAD4_MAX)) begin
          exp_nxt      = (b <= ASCII_MAX) ? 2'd0 : cont_count(b);
          lead_nxt     = b;
          lead_pos_nxt = pos_r;
          bad_nxt      = 1'b0;
          bad_pos_nxt  = '0;
          fault_nxt    = 1'b0;
        end else begin
          err_nxt     = 1'b1;
          err_pos_nxt = pos_r;
        end
      end else begin
        if (is_bad && !bad_r) begin
          bad_nxt     = 1'b1;
          bad_pos_nxt = pos_r;
        end
        if (exp_r == cont_count(lead_r) && range_hit) begin
          fault_nxt = 1'b1;
        end
        exp_nxt = exp_r - 2'd1;
        if (exp_nxt == 2'd0) begin
          if (bad_nxt) begin
            err_nxt     = 1'b1;
            err_pos_nxt = bad_pos_nxt;
          end else if (fault_nxt) begin
            err_nxt     = 1'b1;
            err_pos_nxt = lead_pos_r;
          end
        end
      end
    end
  end

  // Truncated final sequence reports at its lead byte
  assign last_err     = err_nxt || exp_nxt != 2'd0;
  assign last_err_pos = err_nxt ? err_pos_nxt : lead_pos_nxt;
  assign off          = !bom_nxt ? last_err_pos :
                        (last_err_pos >= pos_t'(3)) ? last_err_pos - pos_t'(3) : '0;

  // Build the verdict
  always_comb begin
    verdict.status       = STATUS_VALID;
    verdict.error_offset = '0;
    verdict.has_bom      = bom_nxt;
    if (utf16_nxt) begin
      verdict.status  = STATUS_UTF16;
      verdict.has_bom = 1'b0;
    end else if (last_err) begin
      verdict.status       = STATUS_INVALID;
      verdict.error_offset = OUT_OFFSET_W'(off);
    end
  end

  // Advance state; clear it after the verdict
  always_ff @(posedge clk) begin
    if (!rst_n || verdict_valid) begin
      pos_r      <= '0;
      first_r    <= '0;
      utf16_r    <= 1'b0;
      bom_prog_r <= '0;
      bom_r      <= 1'b0;
      exp_r      <= '0;
      lead_r     <= '0;
      lead_pos_r <= '0;
      bad_r      <= 1'b0;
      bad_pos_r  <= '0;
      fault_r    <= 1'b0;
      err_r      <= 1'b0;
      err_pos_r  <= '0;
    end else if (take) begin
      pos_r      <= pos_nxt;
      first_r    <= first_nxt;
      utf16_r    <= utf16_nxt;
      bom_prog_r <= bom_prog_nxt;
      bom_r      <= bom_nxt;
      exp_r      <= exp_nxt;
      lead_r     <= lead_nxt;
      lead_pos_r <= lead_pos_nxt;
      bad_r      <= bad_nxt;
      bad_pos_r  <= bad_pos_nxt;
      fault_r    <= fault_nxt;
      err_r      <= err_nxt;
      err_pos_r  <= err_pos_nxt;
    end
  end

`ifndef SYNTHESIS
  // Once an error is latched no sequence stays open
  a_err_closed: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> exp_r == 2'd0)
    else $error("sequence open after error latched");

  // A UTF-16 mark needs two bytes seen
  a_utf16_pos: assert property (@(posedge clk) disable iff (!rst_n)
    utf16_r |-> pos_r >= pos_t'(2))
    else $error("UTF-16 mark flagged too early");

  // The UTF-8 mark flag implies a full match
  a_bom_prog: assert property (@(posedge clk) disable iff (!rst_n)
    bom_r |-> bom_prog_r == 2'd3)
    else $error("BOM flag without full match");

  // Error position never lies ahead of the scan
  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> err_pos_r <= pos_r)
    else $error("error position beyond scan position");

  // A verdict starts a new file
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_valid |=> pos_r == '0 && !err_r && exp_r == 2'd0)
    else $error("state not cleared after verdict");
`endif

endmodule
`default_nettype wire

### rtl/u8v_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_out_stage: verdict register
// Holds one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module u8v_out_stage
  import u8v_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire verdict_t verdict,
  output logic          out_free,
  output logic          out_valid,
  input  wire logic     out_ready,
  output verdict_t      out_verdict
);

  logic     valid_r, valid_nxt;
  verdict_t verdict_r;

  // Room when empty or when the held verdict leaves this cycle
  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict;
    end
  end

  assign out_valid   = valid_r;
  assign out_verdict = verdict_r;

endmodule
`default_nettype wire

### rtl/utf8_validator_with_bom.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle, with no gaps between files, while the verdict
//   register has room; a last byte waits while a held verdict is not taken.
// Path: the last byte passes the input register, then the verdict register.
// Reset: synchronous active-low rst_n clears all scan state and both stages;
//   scan state also clears itself after each verdict.
// ----------------------------------------------------------------------------
// utf8_validator_with_bom: streaming UTF-8 validator with mark detection
// Checks a file byte by byte and reports one verdict on its last byte.
// ----------------------------------------------------------------------------
module utf8_validator_with_bom
  import u8v_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic                    in_last_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [OUT_OFFSET_W-1:0]      out_error_offset,
  output logic                         out_has_bom
);

  item_t    in_item;
  item_t    item;
  logic     item_valid;
  logic     take;
  logic     out_free;
  logic     verdict_valid;
  verdict_t verdict;
  verdict_t out_verdict;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  u8v_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  u8v_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .out_free      (out_free),
    .take          (take),
    .verdict_valid (verdict_valid),
    .verdict       (verdict)
  );

  u8v_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (verdict_valid),
    .verdict     (verdict),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

  assign out_status       = out_verdict.status;
  assign out_error_offset = out_verdict.error_offset;
  assign out_has_bom      = out_verdict.has_bom;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: UTF-8 validator with byte-order-mark handling
// Streams whole files through the validator, one byte per request, and checks
// every verdict (status, error offset, UTF-8 mark flag) against a scan model
// kept in a scoreboard. Covers marks, every error kind and its precedence, and
// backpressure.
// ----------------------------------------------------------------------------
module tb;
  import u8v_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 200;
  localparam int MIN_RANDOM_FILES = 30;
  localparam int HOLD_CYCLES = 200;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: byte-level scan of the current file plus queue of verdicts
  // --------------------------------------------------------------------------
  class verdict_scoreboard;
    pos_t       pos;
    logic [7:0] first_b;
    bit         utf16_seen;
    logic [1:0] bom_prog;
    bit         bom_seen;
    logic [1:0] cont_left;
    logic [1:0] lead_tail;
    logic [7:0] lead;
    pos_t       lead_pos;
    bit         bad_cont;
    pos_t       bad_cont_pos;
    bit         range_fault;
    bit         err;
    pos_t       err_pos;

    verdict_t   verdict_q[$];
    int         mismatch_count;
    int         files_valid, files_utf16, files_invalid, files_bom;

    function new();
      clear_scan();
    endfunction

    function void clear_scan();
      pos = '0; first_b = '0; utf16_seen = 0; bom_prog = '0; bom_seen = 0;
      cont_left = '0; lead_tail = '0; lead = '0; lead_pos = '0;
      bad_cont = 0; bad_cont_pos = '0; range_fault = 0; err = 0; err_pos = '0;
    endfunction

    // Keep only the first error of a file
    function void latch(pos_t p);
      if (!err) begin
        err = 1;
        err_pos = p;
      end
    endfunction

    // Advance the UTF-8 sequence check by one content byte
    function void scan_byte(logic [7:0] b, pos_t p);
      logic [1:0] need;
      if (cont_left == 0) begin
        if (b <= ASCII_MAX) begin
          need = 2'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          need = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          need = 2'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          need = 2'd3;
        end else begin
          latch(p);
          return;
        end
        cont_left = need;
        lead_tail = need;
        lead = b;
        lead_pos = p;
        bad_cont = 0;
        bad_cont_pos = '0;
        range_fault = 0;
        return;
      end
      if (b[7:6] != CONT_TAG && !bad_cont) begin
        bad_cont = 1;
        bad_cont_pos = p;
      end
      // second byte of the sequence: apply the overlong/surrogate/range limits
      if (cont_left == lead_tail) begin
        if ((lead == LEAD3_MIN && b < LIM_E0_MIN) || (lead == LEAD_ED && b > LIM_ED_MAX) ||
            (lead == LEAD4_MIN && b < LIM_F0_MIN) || (lead == LEAD4_MAX && b > LIM_F4_MAX))
          range_fault = 1;
      end
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) begin
        if (bad_cont) latch(bad_cont_pos);
        else if (range_fault) latch(lead_pos);
      end
    endfunction

    // Note one accepted request; queue a verdict on the last byte
    function void note_request(logic [7:0] b, logic last);
      pos_t     p;
      verdict_t v;
      p = pos;
      if (p == 0) first_b = b;
      if (p == 1 && ((first_b == UTF16_FF && b == UTF16_FE) ||
                     (first_b == UTF16_FE && b == UTF16_FF)))
        utf16_seen = 1;
      if (p < 3 && pos_t'(bom_prog) == p &&
          ((p == 0 && b == BOM_BYTE0) || (p == 1 && b == BOM_BYTE1) ||
           (p == 2 && b == BOM_BYTE2))) begin
        bom_prog = bom_prog + 2'd1;
        if (p == 2) bom_seen = 1;
      end
      if (!err) scan_byte(b, p);
      if (pos != '1) pos = pos + 1'b1;
      if (!last) return;

      // a sequence still open at the end is truncated
      if (!err && cont_left != 0) latch(lead_pos);
      if (utf16_seen) begin
        v.status = STATUS_UTF16;
        v.error_offset = '0;
        v.has_bom = 1'b0;
        files_utf16++;
      end else if (err) begin
        v.status = STATUS_INVALID;
        v.error_offset = (bom_seen) ? ((err_pos >= 3) ? err_pos - 3 : '0) : err_pos;
        v.has_bom = bom_seen;
        files_invalid++;
      end else begin
        v.status = STATUS_VALID;
        v.error_offset = '0;
        v.has_bom = bom_seen;
        files_valid++;
      end
      if (v.has_bom) files_bom++;
      verdict_q.push_back(v);
      clear_scan();
    endfunction

    // Compare one delivered verdict with the oldest one queued
    function void check_verdict(logic [1:0] status, logic [OUT_OFFSET_W-1:0] offset,
                                logic bom);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected verdict: status %0d offset %0d bom %0d", status, offset, bom);
        return;
      end
      want = verdict_q.pop_front();
      if (status !== want.status || offset !== want.error_offset || bom !== want.has_bom) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("verdict mismatch at %0t: expected status %0d offset %0d bom %0d, got status %0d offset %0d bom %0d",
                   $realtime, want.status, want.error_offset, want.has_bom, status, offset, bom);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and drive signals
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic in_last_byte = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [1:0] out_status;
  logic [OUT_OFFSET_W-1:0] out_error_offset;
  logic out_has_bom;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  utf8_validator_with_bom uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_error_offset (out_error_offset),
    .out_has_bom      (out_has_bom)
  );

  verdict_scoreboard sb = new();
  logic [7:0] file_q[$];
  int burst_left = 0;
  bit steady = 0;
  bit hold_req = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int cycle_count;

  // --------------------------------------------------------------------------
  // Sender: one byte per request, in bursts with random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++)
      send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_code_point();
    int unsigned cp;
    bit edge_pick;
    edge_pick = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: cp = edge_pick ? ($urandom_range(0, 1) ? 32'h7F : 32'h00) : $urandom_range(0, 32'h7F);
      1: cp = edge_pick ? ($urandom_range(0, 1) ? 32'h7FF : 32'h80) : $urandom_range(32'h80, 32'h7FF);
      2: begin
        if (edge_pick) begin
          case ($urandom_range(0, 3))
            0: cp = 32'h800;
            1: cp = 32'hD7FF;
            2: cp = 32'hE000;
            default: cp = 32'hFFFF;
          endcase
        end else begin
          cp = $urandom_range(32'h800, 32'hFFFF);
          // step out of the surrogate range
          if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
        end
      end
      default: cp = edge_pick ? ($urandom_range(0, 1) ? 32'h10FFFF : 32'h10000)
                              : $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return cp;
  endfunction

  // Encode one code point as UTF-8
  function automatic void push_char(int unsigned cp);
    if (cp < 32'h80) begin
      file_q.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      file_q.push_back(8'hC0 | cp[10:6]);
      file_q.push_back(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      file_q.push_back(8'hE0 | cp[15:12]);
      file_q.push_back(8'h80 | cp[11:6]);
      file_q.push_back(8'h80 | cp[5:0]);
    end else begin
      file_q.push_back(8'hF0 | cp[20:18]);
      file_q.push_back(8'h80 | cp[17:12]);
      file_q.push_back(8'h80 | cp[11:6]);
      file_q.push_back(8'h80 | cp[5:0]);
    end
  endfunction

  function automatic void add_text(bit with_bom);
    int n;
    if (with_bom) begin
      file_q.push_back(BOM_BYTE0);
      file_q.push_back(BOM_BYTE1);
      file_q.push_back(BOM_BYTE2);
    end
    n = $urandom_range(with_bom ? 0 : 1, 5);
    repeat (n) push_char(pick_code_point());
  endfunction

  // Break a well-formed file in one of several ways
  function automatic void corrupt_file();
    int at;
    logic [7:0] lead_b;
    at = $urandom_range(0, file_q.size() - 1);
    case ($urandom_range(0, 4))
      0: file_q[at] = $urandom_range(0, 255);
      1: begin
        if (file_q.size() > 1) void'(file_q.pop_back());
        else file_q[0] = $urandom_range(8'h80, 8'hFF);
      end
      2: file_q.insert(at, $urandom_range(8'h80, 8'hFF));
      3: file_q.push_back($urandom_range(LEAD2_MIN, LEAD4_MAX));
      default: begin
        // lead with a second-byte limit, then any continuation bytes
        case ($urandom_range(0, 3))
          0: lead_b = LEAD3_MIN;
          1: lead_b = LEAD_ED;
          2: lead_b = LEAD4_MIN;
          default: lead_b = LEAD4_MAX;
        endcase
        file_q.push_back(lead_b);
        repeat ((lead_b >= LEAD4_MIN) ? 3 : 2)
          file_q.push_back($urandom_range(8'h80, 8'hBF));
      end
    endcase
  endfunction

  function automatic void make_random_file();
    int kind;
    int n;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      add_text($urandom_range(0, 3) == 0);
    end else if (kind < 70) begin
      add_text($urandom_range(0, 3) == 0);
      corrupt_file();
    end else if (kind < 80) begin
      if ($urandom_range(0, 1)) begin
        file_q.push_back(UTF16_FF);
        file_q.push_back(UTF16_FE);
      end else begin
        file_q.push_back(UTF16_FE);
        file_q.push_back(UTF16_FF);
      end
      n = $urandom_range(0, 4);
      repeat (n) file_q.push_back($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) file_q.push_back($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hFF)
                                                        : $urandom_range(0, 255));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall pattern by mode, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int tick;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_RANDOM:   out_ready <= ($urandom_range(0, 99) >= 35);
          default:     out_ready <= ((tick % 4) != 3);
        endcase
      end
    end
  end

  // Check each delivered verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(out_status, out_error_offset, out_has_bom);
  end

  // Bound the run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("run timed out after %0d cycles", CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int random_start;
    int random_files;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: marks, lone FF, each error kind and precedence
    file_q = '{8'h7F};                      send_file();
    file_q = '{8'hFF};                      send_file();
    file_q = '{8'hFF, 8'hFE};               send_file();
    file_q = '{8'hFE, 8'hFF};               send_file();
    file_q = '{8'hEF, 8'hBB, 8'hBF, 8'h80}; send_file();
    file_q = '{8'hE0, 8'h9F, 8'h80};        send_file();
    file_q = '{8'hED, 8'hA0, 8'h80};        send_file();
    file_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_file();
    file_q = '{8'hF0, 8'h8F, 8'h41};        send_file();
    file_q = '{8'hC2, 8'h41};               send_file();
    file_q = '{8'h00, 8'hF5};               send_file();

    // Random files until enough bytes and verdicts have gone through
    random_start = bytes_sent;
    random_files = 0;
    while (bytes_sent - random_start < RANDOM_BYTES || random_files < MIN_RANDOM_FILES) begin
      make_random_file();
      send_file();
      random_files++;
    end

    // Hold the receiver off and stream tiny files back to back
    hold_req = 1;
    steady = 1;
    repeat (30) begin
      file_q.delete();
      file_q.push_back($urandom_range(0, 255));
      if ($urandom_range(0, 1)) file_q.push_back($urandom_range(0, 255));
      send_file();
    end
    steady = 0;

    // One long file with a mark and a late error, for wider offsets
    file_q.delete();
    add_text(1);
    repeat (120) file_q.push_back($urandom_range(0, 8'h7F));
    file_q.push_back(8'hC0);
    file_q.push_back(8'h41);
    send_file();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d files in %0d bytes over %0d cycles, with a long output hold.",
             files_sent, bytes_sent, cycle_count);
    $display("Verdicts: %0d valid, %0d UTF-16 rejected, %0d invalid, %0d with UTF-8 mark; %0d mismatches.",
             sb.files_valid, sb.files_utf16, sb.files_invalid, sb.files_bom, sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/u8v_pkg.sv
rtl/u8v_in_stage.sv
rtl/u8v_scan.sv
rtl/u8v_out_stage.sv
rtl/utf8_validator_with_bom.sv
sim/tb.sv
